// ===== hw/rtl/pep_pkg.sv =====
// Shared widths, types and helpers for the plane-from-three-points pipeline.
package pep_pkg;

    localparam int COORD_W     = 32;
    localparam int DIFF_W      = 33;
    localparam int PROD_W      = 66;
    localparam int CROSS_W     = 67;
    localparam int MAG_W       = 66;
    localparam int LEN_W       = 7;
    localparam int SHIFT_W     = 6;
    localparam int SCALED_W    = 31;
    localparam int SQ_W        = 62;
    localparam int SUM_W       = 64;
    localparam int ROOT_W      = 32;
    localparam int NUMER_W     = 62;
    localparam int QUO_W       = 31;
    localparam int NORM_W      = 32;
    localparam int DOT_W       = 66;
    localparam int PD_W        = 34;
    localparam int SQRT_STAGES = 16;
    localparam int DIV_STEPS   = 31;
    localparam int DIV_STAGES  = 16;
    localparam int IN_TDATA_W  = 288;
    localparam int OUT_TDATA_W = 136;

    localparam logic [LEN_W-1:0] TARGET_LEN = LEN_W'(SCALED_W);
    localparam logic [QUO_W-1:0] ONE_Q30    = QUO_W'(1) << 30;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t z;
        coord_t y;
        coord_t x;
    } point_t;

    // Everything the back half needs besides the running root or quotient.
    typedef struct packed {
        logic [2:0][SCALED_W-1:0] s;
        logic [2:0]               neg;
        logic                     degen;
        point_t                   p0;
    } ctx_t;

    function automatic logic [LEN_W-1:0] bit_length(input logic [MAG_W-1:0] v);
        logic [LEN_W-1:0] n;
        n = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (v[i])
            begin
                n = LEN_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

// ===== hw/rtl/plane_equation_from_points.sv =====
// Plane through three points: unit normal and polar distance, fully pipelined.
// Takes three Q16.16 points per word and returns the unit normal (Q1.30) of
// (second - first) x (third - second) plus the polar distance normal . first
// (Q16.16, 34 bits); collinear or coincident points give degenerate = 1 and
// zeros. One word is accepted every cycle while the output is not stalled. The
// pipeline runs through the 16-stage square root (two root bits per stage) and
// the 16-stage restoring divider (two quotient bits per stage, one in the last)
// that follow eight stages of differences, 33x33 products and normalization.
// A stall on the output freezes the whole pipeline; nothing is dropped.
module plane_equation_from_points
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z,
    // third_x, third_y, third_z (32 bits each)
    input  logic [pep_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // normal_x, normal_y, normal_z (32 bits each), polar_distance (34), zero pad (6)
    output logic [pep_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // degenerate
    output logic                              m_axis_tuser
);
    import pep_pkg::*;

    logic adv;
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    coord_t in_c [9];
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            in_c[i] = s_axis_tdata[i*COORD_W +: COORD_W];
        end
    end

    // stage 1: edge vectors
    logic signed [DIFF_W-1:0] a_reg [3];
    logic signed [DIFF_W-1:0] b_reg [3];
    point_t                   p0_1_reg;
    logic                     v1_reg;
    // stage 2: products
    logic signed [PROD_W-1:0] prod_reg [6];
    point_t                   p0_2_reg;
    logic                     v2_reg;
    // stage 3: cross product
    logic signed [CROSS_W-1:0] cross_reg [3];
    point_t                    p0_3_reg;
    logic                      v3_reg;
    // stage 4: magnitudes
    logic [MAG_W-1:0] mag4_reg [3];
    logic [2:0]       neg4_reg;
    point_t           p0_4_reg;
    logic             v4_reg;
    // stage 5: leading bit position
    logic [MAG_W-1:0] mag5_reg [3];
    logic [LEN_W-1:0] len5_reg;
    logic [2:0]       neg5_reg;
    point_t           p0_5_reg;
    logic             v5_reg;
    // stage 6: scaled components
    ctx_t ctx6_reg;
    logic v6_reg;
    // stage 7: squares
    logic [SQ_W-1:0] sq_reg [3];
    ctx_t            ctx7_reg;
    logic            v7_reg;

    // square root pipeline, index 0 is the sum of squares
    logic [SUM_W-1:0]  rt_rem_reg  [SQRT_STAGES+1];
    logic [ROOT_W-1:0] rt_root_reg [SQRT_STAGES+1];
    ctx_t              rt_ctx_reg  [SQRT_STAGES+1];
    logic              rt_vld_reg  [SQRT_STAGES+1];

    // divider pipeline, index 0 is the loaded numerator
    logic [ROOT_W-1:0] dv_rem_reg  [DIV_STAGES+1][3];
    logic [QUO_W-1:0]  dv_work_reg [DIV_STAGES+1][3];
    logic [ROOT_W-1:0] dv_r_reg    [DIV_STAGES+1];
    ctx_t              dv_ctx_reg  [DIV_STAGES+1];
    logic              dv_vld_reg  [DIV_STAGES+1];

    // back end
    logic signed [NORM_W-1:0]  nrm_reg [3];
    logic                      degen_n_reg;
    point_t                    p0_n_reg;
    logic                      vn_reg;
    logic signed [2*COORD_W-1:0] pm_reg [3];
    logic signed [NORM_W-1:0]  nrm_m_reg [3];
    logic                      degen_m_reg;
    logic                      vm_reg;
    logic signed [DOT_W-1:0]   dot_reg;
    logic signed [NORM_W-1:0]  nrm_d_reg [3];
    logic                      degen_d_reg;
    logic                      vd_reg;
    logic [OUT_TDATA_W-1:0]    tdata_reg;
    logic                      tuser_reg;
    logic                      tvalid_reg;

    // combinational helpers for the front end, divider load and back end
    logic [MAG_W-1:0]      mag_or;
    logic [SHIFT_W-1:0]    rshift;
    logic [SHIFT_W-1:0]    lshift;
    logic [MAG_W-1:0]      shifted [3];
    logic [NUMER_W-1:0]    numer [3];
    logic [QUO_W-1:0]      qclamp [3];
    logic signed [DOT_W-1:0] dot_t;

    always_comb
    begin
        mag_or = mag4_reg[0] | mag4_reg[1] | mag4_reg[2];
        rshift = SHIFT_W'(len5_reg - TARGET_LEN);
        lshift = SHIFT_W'(TARGET_LEN - len5_reg);
        for (int i = 0; i < 3; i++)
        begin
            if (len5_reg > TARGET_LEN)
            begin
                shifted[i] = mag5_reg[i] >> rshift;
            end
            else
            begin
                shifted[i] = mag5_reg[i] << lshift;
            end
            numer[i] = (NUMER_W'(rt_ctx_reg[SQRT_STAGES].s[i]) << 30)
                     + NUMER_W'(rt_root_reg[SQRT_STAGES] >> 1);
            qclamp[i] = (dv_work_reg[DIV_STAGES][i] > ONE_Q30) ? ONE_Q30
                      : dv_work_reg[DIV_STAGES][i];
        end
        dot_t = dot_reg + DOT_W'(64'sd1 <<< 29);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            rt_vld_reg[0] <= 1'b0;
            dv_vld_reg[0] <= 1'b0;
            vn_reg        <= 1'b0;
            vm_reg        <= 1'b0;
            vd_reg        <= 1'b0;
            tvalid_reg    <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= s_axis_tvalid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            v6_reg        <= v5_reg;
            v7_reg        <= v6_reg;
            rt_vld_reg[0] <= v7_reg;
            dv_vld_reg[0] <= rt_vld_reg[SQRT_STAGES];
            vn_reg        <= dv_vld_reg[DIV_STAGES];
            vm_reg        <= vn_reg;
            vd_reg        <= vm_reg;
            tvalid_reg    <= vd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_reg[i] <= DIFF_W'(in_c[3+i]) - DIFF_W'(in_c[i]);
                b_reg[i] <= DIFF_W'(in_c[6+i]) - DIFF_W'(in_c[3+i]);
            end
            p0_1_reg <= {in_c[2], in_c[1], in_c[0]};

            prod_reg[0] <= PROD_W'(a_reg[1]) * PROD_W'(b_reg[2]);
            prod_reg[1] <= PROD_W'(a_reg[2]) * PROD_W'(b_reg[1]);
            prod_reg[2] <= PROD_W'(a_reg[2]) * PROD_W'(b_reg[0]);
            prod_reg[3] <= PROD_W'(a_reg[0]) * PROD_W'(b_reg[2]);
            prod_reg[4] <= PROD_W'(a_reg[0]) * PROD_W'(b_reg[1]);
            prod_reg[5] <= PROD_W'(a_reg[1]) * PROD_W'(b_reg[0]);
            p0_2_reg    <= p0_1_reg;

            for (int i = 0; i < 3; i++)
            begin
                cross_reg[i] <= CROSS_W'(prod_reg[2*i]) - CROSS_W'(prod_reg[2*i+1]);
                mag4_reg[i]  <= cross_reg[i][CROSS_W-1] ? MAG_W'(-cross_reg[i])
                                                        : cross_reg[i][MAG_W-1:0];
                neg4_reg[i]  <= cross_reg[i][CROSS_W-1];
                mag5_reg[i]  <= mag4_reg[i];
            end
            p0_3_reg <= p0_2_reg;
            p0_4_reg <= p0_3_reg;

            len5_reg <= bit_length(mag_or);
            neg5_reg <= neg4_reg;
            p0_5_reg <= p0_4_reg;

            for (int i = 0; i < 3; i++)
            begin
                ctx6_reg.s[i] <= shifted[i][SCALED_W-1:0];
                sq_reg[i]     <= SQ_W'(ctx6_reg.s[i]) * SQ_W'(ctx6_reg.s[i]);
            end
            ctx6_reg.neg   <= neg5_reg;
            ctx6_reg.degen <= (len5_reg == '0);
            ctx6_reg.p0    <= p0_5_reg;
            ctx7_reg       <= ctx6_reg;

            rt_rem_reg[0]  <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            rt_root_reg[0] <= '0;
            rt_ctx_reg[0]  <= ctx7_reg;

            for (int i = 0; i < 3; i++)
            begin
                dv_rem_reg[0][i]  <= ROOT_W'(numer[i][NUMER_W-1:QUO_W]);
                dv_work_reg[0][i] <= numer[i][QUO_W-1:0];
                nrm_reg[i] <= dv_ctx_reg[DIV_STAGES].neg[i]
                            ? -NORM_W'(qclamp[i]) : NORM_W'(qclamp[i]);
                // coordinates are signed: extend the sign before the multiply
                pm_reg[i]    <= (2*COORD_W)'(nrm_reg[i])
                              * (2*COORD_W)'(signed'(p0_n_reg[i*COORD_W +: COORD_W]));
                nrm_m_reg[i] <= nrm_reg[i];
                nrm_d_reg[i] <= nrm_m_reg[i];
            end
            dv_r_reg[0]   <= rt_root_reg[SQRT_STAGES];
            dv_ctx_reg[0] <= rt_ctx_reg[SQRT_STAGES];

            degen_n_reg <= dv_ctx_reg[DIV_STAGES].degen;
            p0_n_reg    <= dv_ctx_reg[DIV_STAGES].p0;
            degen_m_reg <= degen_n_reg;

            dot_reg     <= DOT_W'(pm_reg[0]) + DOT_W'(pm_reg[1]) + DOT_W'(pm_reg[2]);
            degen_d_reg <= degen_m_reg;

            if (degen_d_reg)
            begin
                tdata_reg <= '0;
            end
            else
            begin
                tdata_reg <= {6'b0, dot_t[30+PD_W-1:30],
                              nrm_d_reg[2], nrm_d_reg[1], nrm_d_reg[0]};
            end
            tuser_reg <= degen_d_reg;
        end
    end

    // square root: two root bits per stage, remainder kept as v - root^2
    for (genvar k = 0; k < SQRT_STAGES; k++)
    begin : g_sqrt
        logic [SUM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;
        logic [MAG_W-1:0]  trial;

        always_comb
        begin
            rem_next  = rt_rem_reg[k];
            root_next = rt_root_reg[k];
            trial     = '0;
            for (int j = 0; j < 2; j++)
            begin
                trial = (MAG_W'(root_next) << (ROOT_W - 2*k - j))
                      + (MAG_W'(1) << (2*(ROOT_W - 1 - 2*k - j)));
                if (MAG_W'(rem_next) >= trial)
                begin
                    rem_next  = rem_next - trial[SUM_W-1:0];
                    root_next = root_next | (ROOT_W'(1) << (ROOT_W - 1 - 2*k - j));
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rt_vld_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                rt_vld_reg[k+1] <= rt_vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rt_rem_reg[k+1]  <= rem_next;
                rt_root_reg[k+1] <= root_next;
                rt_ctx_reg[k+1]  <= rt_ctx_reg[k];
            end
        end
    end

    // restoring divider: numerator bits shift out of work, quotient bits shift in
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        logic [ROOT_W-1:0] rem_next  [3];
        logic [QUO_W-1:0]  work_next [3];
        logic [ROOT_W:0]   part;

        always_comb
        begin
            part = '0;
            for (int i = 0; i < 3; i++)
            begin
                rem_next[i]  = dv_rem_reg[k][i];
                work_next[i] = dv_work_reg[k][i];
                for (int j = 0; j < 2; j++)
                begin
                    if (2*k + j < DIV_STEPS)
                    begin
                        part = {rem_next[i], work_next[i][QUO_W-1]};
                        if (part >= {1'b0, dv_r_reg[k]})
                        begin
                            part         = part - {1'b0, dv_r_reg[k]};
                            work_next[i] = {work_next[i][QUO_W-2:0], 1'b1};
                        end
                        else
                        begin
                            work_next[i] = {work_next[i][QUO_W-2:0], 1'b0};
                        end
                        rem_next[i] = part[ROOT_W-1:0];
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv_vld_reg[k+1] <= dv_vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    dv_rem_reg[k+1][i]  <= rem_next[i];
                    dv_work_reg[k+1][i] <= work_next[i];
                end
                dv_r_reg[k+1]   <= dv_r_reg[k];
                dv_ctx_reg[k+1] <= dv_ctx_reg[k];
            end
        end
    end

    assign m_axis_tvalid = tvalid_reg;
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tuser  = tuser_reg;

`ifndef ASSERT_OFF
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("degenerate word carries nonzero data");

    a_normal_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[3*NORM_W-1:0] != '0)
        else $error("non-degenerate word has a zero normal");

    a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
        vn_reg |-> (nrm_reg[0] <= 32'sh4000_0000 && nrm_reg[0] >= -32'sh4000_0000
                 && nrm_reg[1] <= 32'sh4000_0000 && nrm_reg[1] >= -32'sh4000_0000
                 && nrm_reg[2] <= 32'sh4000_0000 && nrm_reg[2] >= -32'sh4000_0000))
        else $error("normal component outside unit range");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vd_reg) && $stable(rt_vld_reg[0]))
        else $error("pipeline moved during output stall");
`endif

endmodule
